/* design/vtv_pkg.sv */
// ----------------------------------------------------------------------------
// vtv_pkg
// Shared widths, constants and reset values of the vertex transform block.
// ----------------------------------------------------------------------------
`default_nettype none
package vtv_pkg;

  localparam int COORD_W  = 32;
  localparam int CFG_W    = 64;
  localparam int NUM_REGS = 8;
  localparam int CFG_AW   = 6;

  // clip coordinate: |clip| < 2^48
  localparam int CLIP_W = 50;
  localparam int MAG_W  = 49;
  localparam int PROD_W = 48;

  // quotient bits kept; larger magnitudes clamp, every output saturates anyway
  localparam int QUO_W      = 33;
  localparam int NDC_W      = QUO_W + 1;
  localparam int FRAC_W     = 16;
  localparam int DIV_STAGES = QUO_W + 3;

  localparam int     ONE_Q16   = 65536;
  localparam longint INT32_MAX = 64'sd2147483647;
  localparam longint INT32_MIN = -64'sd2147483648;

  localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

endpackage
`default_nettype wire

/* design/vtv_in_if.sv */
// ----------------------------------------------------------------------------
// vtv_in_if
// Vertex request channel: object-space position with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface vtv_in_if import vtv_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] object_x;
  logic signed [COORD_W-1:0] object_y;
  logic signed [COORD_W-1:0] object_z;

  modport source (output valid, object_x, object_y, object_z, input ready);
  modport sink   (input valid, object_x, object_y, object_z, output ready);
endinterface
`default_nettype wire

/* design/vtv_out_if.sv */
// ----------------------------------------------------------------------------
// vtv_out_if
// Screen-space result channel with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface vtv_out_if import vtv_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] screen_x;
  logic signed [COORD_W-1:0] screen_y;
  logic signed [COORD_W-1:0] depth;
  logic                      w_was_clamped;
  logic                      saturated;

  modport source (output valid, screen_x, screen_y, depth, w_was_clamped, saturated,
                  input ready);
  modport sink   (input valid, screen_x, screen_y, depth, w_was_clamped, saturated,
                  output ready);
endinterface
`default_nettype wire

/* design/vertex_transform_viewport.sv */
// ----------------------------------------------------------------------------
// vertex_transform_viewport
// MVP transform, perspective divide and viewport mapping of Q16.16 vertices.
// ----------------------------------------------------------------------------
// One vertex request enters per cycle and one result leaves per cycle while
// the output is not stalled; most of the pipeline lies in the three pipelined
// dividers (one quotient bit per stage). Every stage holds its own valid bit,
// so empty stages absorb bubbles while the output is stalled. The matrix sits
// in eight 64-bit APB registers at byte address 8*i and must only be written
// while the pipeline is empty.
`default_nettype none
module vertex_transform_viewport import vtv_pkg::*; #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic              clk,
  input  logic              rst_n,
  vtv_in_if.sink            in_vtx,
  vtv_out_if.source         out_pix,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready
);

  localparam int DIM_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int DIM_W   = $clog2(DIM_MAX + 1);
  localparam int T_W     = NDC_W + 1;
  localparam int MUL_W   = T_W + DIM_W + 1;
  localparam int ST_DIV  = 2;
  localparam int ST_T    = ST_DIV + DIV_STAGES;
  localparam int ST_M    = ST_T + 1;
  localparam int ST_O    = ST_M + 1;
  localparam int NS      = ST_O + 1;

  localparam logic signed [DIM_W:0] WIDTH_S  = (DIM_W+1)'(SCREEN_WIDTH);
  localparam logic signed [DIM_W:0] HEIGHT_S = (DIM_W+1)'(SCREEN_HEIGHT);

  // configuration
  logic [CFG_W-1:0] cfg_r [NUM_REGS];
  logic [2:0]       cfg_idx;

  assign cfg_idx = paddr[CFG_AW-1:3];
  assign pready  = 1'b1;
  assign prdata  = cfg_r[cfg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_r[i] <= CFG_RESET[i];
    end else if (psel && penable && pwrite && pready) begin
      cfg_r[cfg_idx] <= pwdata;
    end
  end

  function automatic logic signed [COORD_W-1:0] coef(input int row, input int col);
    logic [CFG_W-1:0] reg_v;
    reg_v = cfg_r[3'(row*2 + col/2)];
    return (col % 2 == 1) ? reg_v[CFG_W-1:COORD_W] : reg_v[COORD_W-1:0];
  endfunction

  // pipeline control
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_pix.ready;
    for (int i = NS - 2; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
  end

  assign in_vtx.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_vtx.valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // stage 0: products, floored to Q16.16
  logic signed [PROD_W-1:0] prod_r [4][3];
  logic signed [COORD_W-1:0] vin [3];

  assign vin[0] = in_vtx.object_x;
  assign vin[1] = in_vtx.object_y;
  assign vin[2] = in_vtx.object_z;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= PROD_W'((64'(coef(r, c)) * 64'(vin[c])) >>> FRAC_W);
        end
      end
    end
  end

  // stage 1: row sums
  logic signed [CLIP_W-1:0] clip_r [4];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int r = 0; r < 4; r++) begin
        clip_r[r] <= CLIP_W'(prod_r[r][0]) + CLIP_W'(prod_r[r][1])
                   + CLIP_W'(prod_r[r][2]) + CLIP_W'(coef(r, 3));
      end
    end
  end

  // perspective divide
  logic                     wz;
  logic signed [CLIP_W-1:0] w_eff;
  logic signed [NDC_W-1:0]  ndc [3];
  logic                     clmp_r [NS-ST_DIV];

  assign wz    = (clip_r[3] == '0);
  assign w_eff = wz ? CLIP_W'(1) : clip_r[3];

  for (genvar a = 0; a < 3; a++) begin : g_div
    vtv_divider u_div (
      .clk (clk),
      .en  (en[ST_DIV +: DIV_STAGES]),
      .num (clip_r[a]),
      .den (w_eff),
      .quo (ndc[a])
    );
  end

  always_ff @(posedge clk) begin
    if (en[ST_DIV]) clmp_r[0] <= wz;
    for (int i = 1; i < NS - ST_DIV; i++) begin
      if (en[ST_DIV+i]) clmp_r[i] <= clmp_r[i-1];
    end
  end

  // viewport offset, scale, then halve and saturate
  logic signed [T_W-1:0]   tx_r, ty_r;
  logic signed [NDC_W-1:0] nz_t_r, nz_m_r;
  logic signed [MUL_W-1:0] mx_r, my_r;
  logic signed [MUL_W-1:0] tx_e, ty_e, ws_e, hs_e;

  assign tx_e = MUL_W'(tx_r);
  assign ty_e = MUL_W'(ty_r);
  assign ws_e = MUL_W'(WIDTH_S);
  assign hs_e = MUL_W'(HEIGHT_S);

  always_ff @(posedge clk) begin
    if (en[ST_T]) begin
      tx_r   <= T_W'(ndc[0]) + T_W'(ONE_Q16);
      ty_r   <= T_W'(ONE_Q16) - T_W'(ndc[1]);
      nz_t_r <= ndc[2];
    end
    if (en[ST_M]) begin
      mx_r   <= tx_e * ws_e;
      my_r   <= ty_e * hs_e;
      nz_m_r <= nz_t_r;
    end
  end

  function automatic logic [COORD_W:0] sat_q(input logic signed [MUL_W-1:0] v);
    logic signed [MUL_W-1:0] hi;
    logic signed [MUL_W-1:0] lo;
    hi = MUL_W'(INT32_MAX);
    lo = MUL_W'(INT32_MIN);
    if (v > hi) return {1'b1, COORD_W'(INT32_MAX)};
    if (v < lo) return {1'b1, COORD_W'(INT32_MIN)};
    return {1'b0, v[COORD_W-1:0]};
  endfunction

  logic [COORD_W:0] sx_s, sy_s, nz_s;
  logic signed [COORD_W-1:0] sx_r, sy_r, dz_r;
  logic sat_r;

  assign sx_s = sat_q(mx_r >>> 1);
  assign sy_s = sat_q(my_r >>> 1);
  assign nz_s = sat_q(MUL_W'(nz_m_r));

  always_ff @(posedge clk) begin
    if (en[ST_O]) begin
      sx_r  <= sx_s[COORD_W-1:0];
      sy_r  <= sy_s[COORD_W-1:0];
      dz_r  <= nz_s[COORD_W-1:0];
      sat_r <= sx_s[COORD_W] | sy_s[COORD_W] | nz_s[COORD_W];
    end
  end

  assign out_pix.valid         = v_r[NS-1];
  assign out_pix.screen_x      = sx_r;
  assign out_pix.screen_y      = sy_r;
  assign out_pix.depth         = dz_r;
  assign out_pix.w_was_clamped = clmp_r[NS-ST_DIV-1];
  assign out_pix.saturated     = sat_r;

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vtx.ready |-> (&v_r))
    else $error("input stalled with an empty stage");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vtx.valid && in_vtx.ready) |=> v_r[0])
    else $error("accepted request not captured");

  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pix.valid && out_pix.saturated) |->
      (sx_r == COORD_W'(INT32_MAX) || sx_r == COORD_W'(INT32_MIN) ||
       sy_r == COORD_W'(INT32_MAX) || sy_r == COORD_W'(INT32_MIN) ||
       dz_r == COORD_W'(INT32_MAX) || dz_r == COORD_W'(INT32_MIN)))
    else $error("saturated flag without a saturated value");
`endif

endmodule
`default_nettype wire

/* design/vtv_divider.sv */
// ----------------------------------------------------------------------------
// vtv_divider
// Pipelined restoring divider: (num * 2^16) / den truncated toward zero,
// one quotient bit per stage, magnitude clamped to 2^QUO_W - 1.
// ----------------------------------------------------------------------------
`default_nettype none
module vtv_divider import vtv_pkg::*; (
  input  logic                     clk,
  input  logic [DIV_STAGES-1:0]    en,
  input  logic signed [CLIP_W-1:0] num,
  input  logic signed [CLIP_W-1:0] den,
  output logic signed [NDC_W-1:0]  quo
);

  localparam int SHIFT = QUO_W - FRAC_W;

  logic                   neg_p_r;
  logic [MAG_W-1:0]       nmag_p_r;
  logic [MAG_W-1:0]       dmag_p_r;
  logic [CLIP_W-1:0]      nabs;
  logic [CLIP_W-1:0]      dabs;

  logic [MAG_W-1:0]       rem_r  [QUO_W];
  logic [MAG_W-1:0]       nmag_r [QUO_W];
  logic [MAG_W-1:0]       dmag_r [QUO_W];
  logic [QUO_W-1:0]       quo_r  [QUO_W+1];
  logic                   neg_r  [QUO_W+1];
  logic                   ovf_r  [QUO_W+1];
  logic signed [NDC_W-1:0] quo_out_r;

  assign nabs = num[CLIP_W-1] ? CLIP_W'(-num) : CLIP_W'(num);
  assign dabs = den[CLIP_W-1] ? CLIP_W'(-den) : CLIP_W'(den);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg_p_r  <= num[CLIP_W-1] ^ den[CLIP_W-1];
      nmag_p_r <= nabs[MAG_W-1:0];
      dmag_p_r <= dabs[MAG_W-1:0];
    end
    if (en[1]) begin
      rem_r[0]  <= nmag_p_r >> SHIFT;
      ovf_r[0]  <= (nmag_p_r >> SHIFT) >= dmag_p_r;
      nmag_r[0] <= nmag_p_r;
      dmag_r[0] <= dmag_p_r;
      neg_r[0]  <= neg_p_r;
      quo_r[0]  <= '0;
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    localparam int K = QUO_W - 1 - j;
    logic           nb;
    logic [MAG_W:0] trial;
    logic           ge;
    logic [MAG_W:0] diff;

    if (K >= FRAC_W) begin : g_bit
      assign nb = nmag_r[j][K-FRAC_W];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign trial = {rem_r[j], nb};
    assign ge    = trial >= {1'b0, dmag_r[j]};
    assign diff  = trial - {1'b0, dmag_r[j]};

    always_ff @(posedge clk) begin
      if (en[j+2]) begin
        quo_r[j+1] <= quo_r[j] | (QUO_W'(ge) << K);
        neg_r[j+1] <= neg_r[j];
        ovf_r[j+1] <= ovf_r[j];
      end
    end

    if (j < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[j+2]) begin
          rem_r[j+1]  <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
          nmag_r[j+1] <= nmag_r[j];
          dmag_r[j+1] <= dmag_r[j];
        end
      end
    end
  end

  logic [NDC_W-1:0] qmag;
  assign qmag = ovf_r[QUO_W] ? {1'b0, {QUO_W{1'b1}}} : {1'b0, quo_r[QUO_W]};

  always_ff @(posedge clk) begin
    if (en[QUO_W+2]) begin
      quo_out_r <= neg_r[QUO_W] ? -$signed(qmag) : $signed(qmag);
    end
  end

  assign quo = quo_out_r;

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Vertex transform and viewport testbench: directed cases first, then random
// matrices and vertices sent in bursts while the result side stalls in odd
// phases; each result is checked per field against a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb;
  import vtv_pkg::*;

  localparam int SCR_W = 640;
  localparam int SCR_H = 480;
  localparam int LAT   = 41;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] dz;
    logic               clamped;
    logic               sat;
  } pix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_W-1:0]  pwdata = '0;
  logic [CFG_W-1:0]  prdata;
  logic              pready;

  vtv_in_if  in_vtx ();
  vtv_out_if out_pix ();

  vertex_transform_viewport #(.SCREEN_WIDTH(SCR_W), .SCREEN_HEIGHT(SCR_H)) dut (
    .clk(clk), .rst_n(rst_n), .in_vtx(in_vtx.sink), .out_pix(out_pix.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [63:0] mvp [NUM_REGS];
  pix_t        pix_expected [$];
  int          mismatches = 0;
  longint      cycles = 0;
  bit          stall_mode = 0;

  initial begin
    in_vtx.valid = 1'b0;
    in_vtx.object_x = '0;
    in_vtx.object_y = '0;
    in_vtx.object_z = '0;
    out_pix.ready = 1'b0;
  end

  function automatic longint coef_of(int r, int c);
    logic [63:0] reg_v;
    reg_v = mvp[r*2 + c/2];
    return (c % 2) ? longint'($signed(reg_v[63:32])) : longint'($signed(reg_v[31:0]));
  endfunction

  function automatic longint quot_q16(longint c, longint w);
    longint unsigned mc, mw, q;
    mc = (c < 0) ? -c : c;
    mw = (w < 0) ? -w : w;
    q = (mc << 16) / mw;
    if (q > (64'd1 << 40)) q = 64'd1 << 40;
    return ((c < 0) != (w < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [31:0] clip32(longint v, ref logic flag);
    if (v > INT32_MAX) begin
      flag = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < INT32_MIN) begin
      flag = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic pix_t project_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    longint v [4];
    longint clip [4];
    longint w, nx, ny, nz;
    pix_t p;
    logic s;
    v[0] = $signed(x);
    v[1] = $signed(y);
    v[2] = $signed(z);
    v[3] = ONE_Q16;
    for (int r = 0; r < 4; r++) begin
      clip[r] = 0;
      for (int c = 0; c < 4; c++) clip[r] += (coef_of(r, c) * v[c]) >>> 16;
    end
    w = clip[3];
    p.clamped = (w == 0);
    if (w == 0) w = 1;
    nx = quot_q16(clip[0], w);
    ny = quot_q16(clip[1], w);
    nz = quot_q16(clip[2], w);
    s = 1'b0;
    p.sx = clip32(((nx + ONE_Q16) * SCR_W) >>> 1, s);
    p.sy = clip32(((ONE_Q16 - ny) * SCR_H) >>> 1, s);
    p.dz = clip32(nz, s);
    p.sat = s;
    return p;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** vertex_transform_viewport: FAILED **");
      $finish;
    end
  end

  // result side: stall pattern alternates between none and random
  always @(posedge clk) begin
    if (!rst_n) out_pix.ready <= 1'b0;
    else if (!stall_mode) out_pix.ready <= 1'b1;
    else out_pix.ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    pix_t got, want;
    if (rst_n && out_pix.valid && out_pix.ready) begin
      got = '{out_pix.screen_x, out_pix.screen_y, out_pix.depth,
              out_pix.w_was_clamped, out_pix.saturated};
      if (pix_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pix_expected.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  task automatic cfg_write(int idx, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(idx * 8);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    mvp[idx] = val;
    @(posedge clk);
  endtask

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    in_vtx.valid <= 1'b1;
    in_vtx.object_x <= x;
    in_vtx.object_y <= y;
    in_vtx.object_z <= z;
    do @(posedge clk); while (!in_vtx.ready);
    pix_expected = {pix_expected, project_vertex(x, y, z)};
  endtask

  int burst_left = 0;

  task automatic send_paced(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_vtx.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    send_vertex(x, y, z);
  endtask

  task automatic drain();
    in_vtx.valid <= 1'b0;
    while (pix_expected.size() != 0) @(posedge clk);
    repeat (LAT + 5) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(0, 2**21)) - 2**20);
    endcase
  endfunction

  function automatic logic [31:0] rnd_coef();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h0;
      default: return 32'($signed($urandom_range(0, 2**18)) - 2**17);
    endcase
  endfunction

  task automatic test_identity();
    logic [31:0] edges [6] = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff,
                               32'h8000_0000, 32'h0001_0000};
    foreach (edges[i]) send_vertex(edges[i], edges[(i+1)%6], edges[(i+2)%6]);
    send_vertex(32'h0000_8000, 32'hffff_8000, 32'h0000_4000);
    drain();
  endtask

  task automatic test_zero_and_negative_w();
    for (int i = 0; i < NUM_REGS; i++) cfg_write(i, 64'h0);
    cfg_write(0, 64'h0000_0000_0001_0000);
    cfg_write(2, 64'h0001_0000_0000_0000);
    send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0);
    send_vertex(32'h0, 32'h0, 32'h0);
    drain();
    cfg_write(7, 64'hffff_0000_0000_0000);
    cfg_write(5, 64'h0000_0000_0001_0000);
    send_vertex(32'h0000_8000, 32'h0000_4000, 32'h0003_0000);
    drain();
    cfg_write(6, 64'h0000_0000_0001_0000);
    send_vertex(32'h0001_0000, 32'h0, 32'h0);
    send_vertex(32'h0000_0001, 32'h0, 32'h0);
    drain();
  endtask

  task automatic test_extreme_matrix();
    for (int i = 0; i < NUM_REGS; i++) cfg_write(i, 64'h8000_0000_8000_0000);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    drain();
    for (int i = 0; i < NUM_REGS; i++) cfg_write(i, 64'hffff_ffff_ffff_ffff);
    send_vertex(32'h7fff_ffff, 32'h0, 32'h8000_0000);
    send_vertex($urandom(), $urandom(), $urandom());
    drain();
    for (int i = 0; i < NUM_REGS; i++) cfg_write(i, 64'h7fff_ffff_7fff_ffff);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h1);
    send_vertex($urandom(), $urandom(), $urandom());
    drain();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 10; phase++) begin
      stall_mode = phase[0];
      for (int i = 0; i < NUM_REGS; i++) cfg_write(i, {rnd_coef(), rnd_coef()});
      if (phase % 3 == 0) cfg_write(7, {32'h0001_0000, rnd_coef()});
      repeat (63) send_paced(rnd_coord(), rnd_coord(), rnd_coord());
      drain();
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) mvp[i] = CFG_RESET[i];
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity();
    test_zero_and_negative_w();
    test_extreme_matrix();
    test_random();
    if (mismatches == 0 && pix_expected.size() == 0)
      $display("** vertex_transform_viewport: PASSED **");
    else
      $display("** vertex_transform_viewport: FAILED **");
    $finish;
  end
endmodule

/* vertex_transform_viewport.f */
design/vtv_pkg.sv
design/vtv_in_if.sv
design/vtv_out_if.sv
design/vtv_divider.sv
design/vertex_transform_viewport.sv
tb/sv/tb.sv
